// ----- rtl/core/rldd_pkg.sv -----
// Shared types and constants for the register list dictionary encoder.
package rldd_pkg;

    localparam int DICT_DEPTH = 16;
    localparam int MAX_GROUPS = 64;
    localparam int JOBQ_DEPTH = 2;

    localparam int WORD_W  = 32;
    localparam int POS_W   = 16;
    localparam int GNUM_W  = 6;
    localparam int DICT_AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int KEY_CW  = $clog2(DICT_DEPTH + 1);
    localparam int GRP_CW  = $clog2(MAX_GROUPS + 1);
    localparam int JQ_AW   = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int JQ_CW   = $clog2(JOBQ_DEPTH + 1);

    localparam logic [WORD_W-1:0] GROUP_END = '1;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_DICT_FULL  = 2'd1,
        ERR_GROUP_FULL = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_KEY    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        BS_IDLE   = 2'd0,
        BS_SEARCH = 2'd1,
        BS_DONE   = 2'd2
    } t_bstate;

    // classified word handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic              gstart;
        logic [GNUM_W-1:0] gnum;
        t_err              err;
        logic              last;
        logic              is_key;
    } t_job;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic              gstart;
        logic [GNUM_W-1:0] gnum;
        logic              newk;
        t_err              err;
        logic              last;
    } t_res;

endpackage

// ----- rtl/core/rldd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rldd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/rldd_front.sv -----
// Front end: accepts list words, tracks record phase, positions and group starts.
module rldd_front import rldd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_q_full,
    input  logic [WORD_W-1:0] i_list_word,
    input  logic              i_last_word,
    input  logic              i_cfg_valid,
    input  logic [POS_W-1:0]  i_cfg_start_position,
    output logic              o_cfg_ready,
    output logic              o_q_push,
    output t_job              o_job
);

    t_phase            r_phase, n_phase;
    logic              r_pending, n_pending;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_start;
    logic [GRP_CW-1:0] r_group_count, n_group_count;
    logic              accept;
    logic              cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign accept      = i_push && !i_q_full;
    assign o_q_push    = accept;

    always_comb begin
        n_phase       = r_phase;
        n_pending     = r_pending;
        n_group_count = r_group_count;
        n_pos         = r_pos + 1'b1;
        o_job.word    = i_list_word;
        o_job.pos     = r_pos;
        o_job.gstart  = 1'b0;
        o_job.gnum    = '0;
        o_job.err     = ERR_OK;
        o_job.last    = i_last_word;
        o_job.is_key  = 1'b0;
        unique case (r_phase)
            PH_FIRST: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    if (r_group_count >= GRP_CW'(MAX_GROUPS)) begin
                        o_job.err = ERR_GROUP_FULL;
                    end else begin
                        o_job.gstart  = 1'b1;
                        o_job.gnum    = GNUM_W'(r_group_count);
                        n_group_count = r_group_count + 1'b1;
                    end
                end
                if (i_list_word == GROUP_END) begin
                    n_pending = 1'b1;
                end else begin
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                n_phase = PH_KEY;
            end
            PH_KEY: begin
                o_job.is_key = 1'b1;
                n_phase      = PH_FIRST;
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
        // end of list, also when cut short mid-record
        if (i_last_word) begin
            n_phase   = PH_FIRST;
            n_pending = 1'b1;
            n_pos     = r_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_FIRST;
            r_pending     <= 1'b1;
            r_pos         <= '0;
            r_start       <= '0;
            r_group_count <= '0;
        end else if (cfg_wr) begin
            r_start <= i_cfg_start_position;
            r_pos   <= i_cfg_start_position;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_pending     <= n_pending;
            r_pos         <= n_pos;
            r_group_count <= n_group_count;
        end
    end

endmodule

// ----- rtl/core/rldd_queue.sv -----
// Short job queue decoupling the front end from the dictionary back end.
module rldd_queue import rldd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job             r_mem [JOBQ_DEPTH];
    logic [JQ_AW-1:0] r_wp, r_rp;
    logic [JQ_CW-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == JQ_CW'(JOBQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == JQ_AW'(JOBQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == JQ_AW'(JOBQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= JQ_CW'(JOBQ_DEPTH))
        else $error("job queue count over depth");
`endif

endmodule

// ----- rtl/core/rldd_back.sv -----
// Back end: serial dictionary search, key append and the result register.
module rldd_back import rldd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_job i_q_job,
    output logic o_q_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    t_bstate            r_state, n_state;
    t_job               r_job, n_job;
    logic [KEY_CW-1:0]  r_idx, n_idx;
    logic               r_cmp_valid, n_cmp_valid;
    logic [DICT_AW-1:0] r_cmp_idx, n_cmp_idx;
    logic               r_found, n_found;
    logic [DICT_AW-1:0] r_hit_idx, n_hit_idx;
    logic [KEY_CW-1:0]  r_key_count, n_key_count;
    logic               r_out_valid;
    t_res               r_out;

    logic               slot_free;
    logic               emit;
    t_res               res;
    logic               ram_we;
    logic [WORD_W-1:0]  ram_rdata;
    logic               hit;

    rldd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_key_count[DICT_AW-1:0]),
        .i_wdata (r_job.word),
        .i_raddr (r_idx[DICT_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign slot_free = !r_out_valid || i_pop;
    // read data belongs to the address issued last cycle
    assign hit       = r_cmp_valid && (ram_rdata == r_job.word);

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        n_cmp_valid = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_key_count = r_key_count;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        emit        = 1'b0;
        res.word    = r_job.word;
        res.pos     = r_job.pos;
        res.gstart  = r_job.gstart;
        res.gnum    = r_job.gnum;
        res.newk    = 1'b0;
        res.err     = r_job.err;
        res.last    = r_job.last;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    if (!i_q_job.is_key) begin
                        if (slot_free) begin
                            emit       = 1'b1;
                            o_q_pop    = 1'b1;
                            res.word   = i_q_job.word;
                            res.pos    = i_q_job.pos;
                            res.gstart = i_q_job.gstart;
                            res.gnum   = i_q_job.gnum;
                            res.err    = i_q_job.err;
                            res.last   = i_q_job.last;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        n_job   = i_q_job;
                        n_idx   = '0;
                        n_state = BS_SEARCH;
                    end
                end
            end
            BS_SEARCH: begin
                if (hit) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_state   = BS_DONE;
                end else if (r_idx == r_key_count) begin
                    n_found = 1'b0;
                    n_state = BS_DONE;
                end else begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[DICT_AW-1:0];
                    n_idx       = r_idx + 1'b1;
                end
            end
            BS_DONE: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = BS_IDLE;
                    if (r_found) begin
                        res.word = WORD_W'(r_hit_idx);
                    end else if (r_key_count >= KEY_CW'(DICT_DEPTH)) begin
                        res.word = '0;
                        res.err  = ERR_DICT_FULL;
                    end else begin
                        ram_we      = 1'b1;
                        res.word    = WORD_W'(r_key_count);
                        res.newk    = 1'b1;
                        n_key_count = r_key_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_cmp_valid <= 1'b0;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= n_cmp_valid;
            r_key_count <= n_key_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_hit_idx <= n_hit_idx;
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_key_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= KEY_CW'(DICT_DEPTH))
        else $error("dictionary count over depth");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SEARCH) |-> (r_idx <= r_key_count))
        else $error("search index past dictionary fill");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_key_count == $past(r_key_count) + 1'b1))
        else $error("key append without count update");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("result changed while stalled");
`endif

endmodule

// ----- rtl/core/register_list_index_dedup.sv -----
// Top level of the register list dictionary encoder.
// Usage:
//   Input queue side: push a word with its last flag when full is low; one beat
//   per list word. Result queue side: while empty is low the oldest result is on
//   the o_ ports; pop takes it. One result beat per input beat, in order.
//   Config: i_cfg_valid writes start_position (o_cfg_ready is always high) and
//   restarts position numbering; write only while the block is idle.
// Operation:
//   Pass-through words pass the job queue and enter the result register when the
//   back end is idle and the result slot is free. A key word runs a serial search
//   of the dictionary RAM, one entry per cycle against the registered read data,
//   then decides and appends once the result slot is free.
//   A record is 3 words; only its third (key) word is searched.
//   A 2-entry job queue lets the front accept words during a search.
// Reset: synchronous, active low; clears the phase, counters and dictionary
//   fill count; no clearing pass. A stalled result holds and backs up the queue,
//   which then raises full.
module register_list_index_dedup import rldd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] i_list_word,
    input  logic              i_last_word,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] o_word_out,
    output logic [POS_W-1:0]  o_position_out,
    output logic              o_group_start,
    output logic [GNUM_W-1:0] o_group_number,
    output logic              o_new_key,
    output logic [1:0]        o_error_code,
    output logic              o_done_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [POS_W-1:0]  i_cfg_start_position
);

    logic q_full, q_empty, q_push, q_pop;
    t_job front_job, q_job;
    t_res res;

    rldd_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_push               (push),
        .i_q_full             (q_full),
        .i_list_word          (i_list_word),
        .i_last_word          (i_last_word),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_start_position (i_cfg_start_position),
        .o_cfg_ready          (o_cfg_ready),
        .o_q_push             (q_push),
        .o_job                (front_job)
    );

    rldd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    rldd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign full           = q_full;
    assign o_word_out     = res.word;
    assign o_position_out = res.pos;
    assign o_group_start  = res.gstart;
    assign o_group_number = res.gnum;
    assign o_new_key      = res.newk;
    assign o_error_code   = res.err;
    assign o_done_res     = res.last;

endmodule
